// ----- rtl/bast_pkg.sv -----
// Shared constants and codes for the baseline average sample table.
package bast_pkg;

  localparam int DATA_W = 32;

  // Request type codes.
  localparam logic [2:0] REQ_SAVE    = 3'd0;
  localparam logic [2:0] REQ_AVG     = 3'd1;
  localparam logic [2:0] REQ_LAST    = 3'd2;
  localparam logic [2:0] REQ_CYCLE   = 3'd3;
  localparam logic [2:0] REQ_CLR_CYC = 3'd4;
  localparam logic [2:0] REQ_CLR_ALL = 3'd5;

  // Response status codes.
  localparam logic [1:0] ST_VALUE   = 2'd0;
  localparam logic [1:0] ST_STORED  = 2'd1;
  localparam logic [1:0] ST_CLEARED = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

endpackage

// ----- rtl/baseline_average_sample_table.sv -----
// Baseline average sample table: per port, chamber and channel sample stores and queries.
// One transaction is worked at a time. Last and cycle value queries pass S_INFO_RD and
// S_INFO_USE before S_RESP, saves pass that pair once per channel, rejects and clears
// go straight to S_RESP. An average query reads the store once per stored sample, then
// runs a serial divide. Reset clears the control state, the count and value valid bits
// and the configuration register at once; no clearing pass is run.
module baseline_average_sample_table #(
  parameter int CHAMBERS   = 4,
  parameter int BASE_DEPTH = 16,
  parameter int PORTS      = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [2:0]                  req_type,
  input  logic                        port_sel,
  input  logic [7:0]                  chamber,
  input  logic [1:0]                  channel_sel,
  input  logic [bast_pkg::DATA_W-1:0] sample_a,
  input  logic [bast_pkg::DATA_W-1:0] sample_b,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [bast_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                  status
);
  import bast_pkg::*;

  localparam int NE  = PORTS * CHAMBERS * 2;
  localparam int EW  = $clog2(NE);
  localparam int CW  = $clog2(BASE_DEPTH + 1);
  localparam int SW  = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
  localparam int SD  = NE * BASE_DEPTH;
  localparam int SAW = $clog2(SD);
  localparam int CHW = (CHAMBERS > 1) ? $clog2(CHAMBERS) : 1;
  localparam int PRW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int IW  = CW + 2 * DATA_W;

  typedef enum logic [2:0] {
    S_IDLE, S_INFO_RD, S_INFO_USE, S_SUM, S_DIV, S_RESP
  } state_t;

  state_t state;

  logic              module_ready;
  logic [2:0]        req_q;
  logic [PRW-1:0]    port_q;
  logic [CHW-1:0]    cham_q;
  logic              ch_cur;
  logic [DATA_W-1:0] sa_q;
  logic [DATA_W-1:0] sb_q;

  logic [NE-1:0]     ent_valid;
  logic [NE-1:0]     cyc_valid;
  logic              ent_v_q;
  logic              cyc_v_q;

  // Per entry record: count, last value, cycle value.
  logic [IW-1:0]     info_mem [NE];
  logic [IW-1:0]     info_q;
  logic              info_re;
  logic              info_we;
  logic [IW-1:0]     info_wdata;

  logic [DATA_W-1:0] store_mem [SD];
  logic [DATA_W-1:0] store_q;
  logic              store_re;
  logic              store_we;
  logic [SAW-1:0]    store_raddr;
  logic [SAW-1:0]    store_waddr;

  logic [EW-1:0]     cur_entry;
  logic [SAW-1:0]    entry_base;
  logic [CW-1:0]     cnt_m;
  logic [CW-1:0]     cnt_next;
  logic [DATA_W-1:0] last_m;
  logic [DATA_W-1:0] cyc_m;
  logic [DATA_W-1:0] cur_sample;
  logic              place_ok;

  logic [CW-1:0]     n_q;
  logic [CW-1:0]     idx_q;
  logic [SAW-1:0]    base_q;
  logic              sum_pend;
  logic [DATA_W-1:0] sum_q;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  logic [DATA_W-1:0] res_value;
  logic [1:0]        res_status;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    place_ok   = (32'(port_sel) < PORTS) && (chamber != 8'd0) &&
                 (32'(chamber) <= CHAMBERS);
    cur_entry  = EW'((int'(port_q) * CHAMBERS + int'(cham_q)) * 2 + int'(ch_cur));
    entry_base = SAW'(int'(cur_entry) * BASE_DEPTH);
    cnt_m      = ent_v_q ? info_q[IW-1 -: CW] : '0;
    last_m     = ent_v_q ? info_q[2*DATA_W-1 -: DATA_W] : '0;
    cyc_m      = cyc_v_q ? info_q[DATA_W-1:0] : '0;
    cur_sample = ch_cur ? sb_q : sa_q;
    cnt_next   = (int'(cnt_m) < BASE_DEPTH) ? cnt_m + 1'b1 : cnt_m;

    info_re    = (state == S_INFO_RD);
    info_we    = (state == S_INFO_USE) && (req_q == REQ_SAVE);
    info_wdata = {cnt_next, cur_sample, cur_sample};
    store_we   = info_we && (int'(cnt_m) < BASE_DEPTH);
    store_waddr = entry_base + SAW'(SW'(cnt_m));
    store_re   = (state == S_SUM) && (idx_q < n_q);
    store_raddr = base_q + SAW'(idx_q);
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[cur_entry] <= info_wdata;
    end
    if (info_re) begin
      info_q <= info_mem[cur_entry];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= cur_sample;
    end
    if (store_re) begin
      store_q <= store_mem[store_raddr];
    end
  end

  bast_div #(.DVW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_q),
    .divisor  (n_q),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      module_ready <= 1'b0;
      ent_valid    <= '0;
      cyc_valid    <= '0;
      rsp_valid    <= 1'b0;
      div_start    <= 1'b0;
      sum_pend     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        module_ready <= cfg_data;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q      <= req_type;
            port_q     <= PRW'(port_sel);
            cham_q     <= CHW'(chamber - 8'd1);
            sa_q       <= sample_a;
            sb_q       <= sample_b;
            ch_cur     <= (req_type == REQ_SAVE) ? 1'b0 : channel_sel[0];
            res_value  <= '0;
            res_status <= ST_REJECT;
            state      <= S_RESP;
            if (req_type == REQ_CLR_CYC) begin
              cyc_valid  <= '0;
              res_status <= ST_CLEARED;
            end else if (req_type == REQ_CLR_ALL) begin
              ent_valid  <= '0;
              cyc_valid  <= '0;
              res_status <= ST_CLEARED;
            end else if (req_type <= REQ_CYCLE && module_ready && place_ok &&
                         (req_type == REQ_SAVE || !channel_sel[1])) begin
              state <= S_INFO_RD;
            end
          end
        end

        S_INFO_RD: begin
          ent_v_q <= ent_valid[cur_entry];
          cyc_v_q <= cyc_valid[cur_entry];
          state   <= S_INFO_USE;
        end

        S_INFO_USE: begin
          res_status <= ST_VALUE;
          state      <= S_RESP;
          priority if (req_q == REQ_SAVE) begin
            ent_valid[cur_entry] <= 1'b1;
            cyc_valid[cur_entry] <= 1'b1;
            res_status           <= ST_STORED;
            if (!ch_cur) begin
              ch_cur <= 1'b1;
              state  <= S_INFO_RD;
            end
          end else if (req_q == REQ_LAST) begin
            res_value <= last_m;
          end else if (req_q == REQ_CYCLE) begin
            res_value <= cyc_m;
          end else begin
            // Average: an empty store answers zero without a divide.
            n_q      <= cnt_m;
            base_q   <= entry_base;
            idx_q    <= '0;
            sum_q    <= '0;
            sum_pend <= 1'b0;
            if (cnt_m != '0) begin
              state <= S_SUM;
            end
          end
        end

        S_SUM: begin
          if (store_re) begin
            idx_q <= idx_q + 1'b1;
          end
          sum_pend <= store_re;
          if (sum_pend) begin
            sum_q <= sum_q + store_q;
          end
          if (!store_re && !sum_pend) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            res_value <= div_quo;
            state     <= S_RESP;
          end
        end

        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            result_value <= res_value;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_type == REQ_CLR_ALL) |=>
      (ent_valid == '0 && cyc_valid == '0))
    else $error("clear-all transaction left valid bits set");

  a_sum_pend: assert property (@(posedge clk) disable iff (rst)
    sum_pend |-> (state == S_SUM))
    else $error("store read pending outside summation");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished while not awaited");

  a_nonzero_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> (n_q != '0))
    else $error("summation started with an empty store");
`endif

endmodule

// ----- rtl/bast_div.sv -----
// Serial restoring divider: one quotient bit per cycle.
module bast_div #(
  parameter int DVW = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bast_pkg::DATA_W-1:0] dividend,
  input  logic [DVW-1:0]              divisor,
  output logic                        done,
  output logic [bast_pkg::DATA_W-1:0] quotient
);
  import bast_pkg::*;

  localparam int CNTW = $clog2(DATA_W);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DVW-1:0]  rem;
  logic [DATA_W-1:0] quo;
  logic [DVW:0]    shifted;
  logic [DVW:0]    diff;
  logic            ge;
  logic [DVW-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[DATA_W-1]};
    ge       = shifted >= {1'b0, divisor};
    diff     = shifted - {1'b0, divisor};
    rem_next = ge ? diff[DVW-1:0] : shifted[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DATA_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- sim/tb.sv -----
// Testbench for the baseline average sample table: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import bast_pkg::*;

  localparam int CHAMBERS   = 4;
  localparam int BASE_DEPTH = 16;
  localparam int PORTS      = 2;
  localparam int NUM_DIR    = 26;

  // Request codes the block does not define.
  localparam logic [2:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [2:0] REQ_UNDEF_HI = 3'd7;

  // Detection channel select codes.
  localparam logic [1:0] CH_FIRST     = 2'd0;
  localparam logic [1:0] CH_SECOND    = 2'd1;
  localparam logic [1:0] CH_INVALID_2 = 2'd2;
  localparam logic [1:0] CH_INVALID_3 = 2'd3;

  typedef struct packed {
    logic        is_cfg;
    logic        cfg_val;
    logic [2:0]  kind;
    logic        port;
    logic [7:0]  cham;
    logic [1:0]  ch;
    logic [31:0] a;
    logic [31:0] b;
    logic        fixed;
    logic [31:0] fval;
    logic [1:0]  fst;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [2:0]  req_type = '0;
  logic        port_sel = 1'b0;
  logic [7:0]  chamber = '0;
  logic [1:0]  channel_sel = '0;
  logic [31:0] sample_a = '0;
  logic [31:0] sample_b = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [31:0] result_value;
  logic [1:0]  status;

  // Predictor state.
  logic [31:0] base_store [PORTS][CHAMBERS][2][BASE_DEPTH];
  logic [4:0]  base_count [PORTS][CHAMBERS][2];
  logic [31:0] last_val [PORTS][CHAMBERS][2];
  logic [31:0] cyc_val [PORTS][CHAMBERS][2];
  logic        ready_copy;

  logic [31:0] resp_value_q[$];
  logic [1:0]  resp_status_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  dir_row_t    dir_rows [NUM_DIR];

  baseline_average_sample_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_type     (req_type),
    .port_sel     (port_sel),
    .chamber      (chamber),
    .channel_sel  (channel_sel),
    .sample_a     (sample_a),
    .sample_b     (sample_b),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .result_value (result_value),
    .status       (status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void clear_baseline_model(input logic cycle_only);
    for (int p = 0; p < PORTS; p++) begin
      for (int c = 0; c < CHAMBERS; c++) begin
        for (int k = 0; k < 2; k++) begin
          cyc_val[p][c][k] = '0;
          if (!cycle_only) begin
            base_count[p][c][k] = '0;
            last_val[p][c][k] = '0;
          end
        end
      end
    end
  endfunction

  function automatic void predict_table_response(
    input  logic [2:0]  kind,
    input  logic        port,
    input  logic [7:0]  cham,
    input  logic [1:0]  ch,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] val,
    output logic [1:0]  st
  );
    logic        place_ok;
    logic [31:0] smp [2];
    logic [31:0] sum;
    int          p;
    int          c;
    int          n;
    val = '0;
    st = ST_REJECT;
    smp[0] = a;
    smp[1] = b;
    place_ok = (int'(port) < PORTS) && (cham >= 8'd1) && (int'(cham) <= CHAMBERS);
    p = int'(port);
    c = int'(cham) - 1;
    if (kind == REQ_CLR_CYC) begin
      clear_baseline_model(1'b1);
      st = ST_CLEARED;
    end else if (kind == REQ_CLR_ALL) begin
      clear_baseline_model(1'b0);
      st = ST_CLEARED;
    end else if (kind <= REQ_CYCLE && ready_copy && place_ok) begin
      if (kind == REQ_SAVE) begin
        // A full store keeps its samples, but last and cycle values still move.
        for (int k = 0; k < 2; k++) begin
          if (int'(base_count[p][c][k]) < BASE_DEPTH) begin
            base_store[p][c][k][base_count[p][c][k]] = smp[k];
            base_count[p][c][k] = base_count[p][c][k] + 5'd1;
          end
          last_val[p][c][k] = smp[k];
          cyc_val[p][c][k] = smp[k];
        end
        st = ST_STORED;
      end else if (ch <= CH_SECOND) begin
        case (kind)
          REQ_AVG: begin
            n = int'(base_count[p][c][ch]);
            sum = '0;
            for (int i = 0; i < n; i++) begin
              sum = sum + base_store[p][c][ch][i];
            end
            val = (n == 0) ? '0 : sum / 32'(n);
          end
          REQ_LAST: val = last_val[p][c][ch];
          default: val = cyc_val[p][c][ch];
        endcase
        st = ST_VALUE;
      end
    end
  endfunction

  function automatic void report_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    mismatches++;
    $display("[%0t] %s mismatch: expected %h, actual %h", $time, what, want, got);
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  // Response checker: each transaction is matched against the oldest expectation.
  always @(posedge clk) begin : rsp_check
    logic [31:0] want_val;
    logic [1:0]  want_st;
    if (!rst && rsp_valid && rsp_ready) begin
      if (resp_value_q.size() == 0) begin
        mismatches++;
        $display("[%0t] unexpected response: expected none, actual %h status %0d",
                 $time, result_value, status);
      end else begin
        want_val = resp_value_q.pop_front();
        want_st = resp_status_q.pop_front();
        if (result_value !== want_val) begin
          report_mismatch("result_value", want_val, result_value);
        end
        if (status !== want_st) begin
          report_mismatch("status", 32'(want_st), 32'(status));
        end
      end
    end
  end

  task automatic send_req(
    input logic [2:0]  kind,
    input logic        port,
    input logic [7:0]  cham,
    input logic [1:0]  ch,
    input logic [31:0] a,
    input logic [31:0] b,
    input logic        fixed,
    input logic [31:0] fval,
    input logic [1:0]  fst
  );
    logic [31:0] pv;
    logic [1:0]  ps;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    port_sel <= port;
    chamber <= cham;
    channel_sel <= ch;
    sample_a <= a;
    sample_b <= b;
    do @(posedge clk); while (!req_ready);
    predict_table_response(kind, port, cham, ch, a, b, pv, ps);
    resp_value_q.push_back(fixed ? fval : pv);
    resp_status_q.push_back(fixed ? fst : ps);
  endtask

  task automatic wait_responses_done();
    req_valid <= 1'b0;
    do @(posedge clk); while (resp_value_q.size() != 0);
  endtask

  task automatic write_ready(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    ready_copy = v;
    cfg_valid <= 1'b0;
  endtask

  // Mostly fill sequences on one port and chamber, which run stores into the full
  // state, with queries mixed in; the rest are clears and fully random noise.
  task automatic run_random(input int n_items);
    int          sent;
    int          pick;
    logic        p;
    logic [7:0]  c;
    logic [2:0]  q;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        p = 1'($urandom_range(PORTS - 1));
        c = 8'($urandom_range(CHAMBERS, 1));
        repeat ($urandom_range(20, 1)) begin
          send_req(REQ_SAVE, p, c, 2'($urandom_range(3)), rand_sample(), rand_sample(),
                   1'b0, '0, ST_VALUE);
          sent++;
          if ($urandom_range(99) < 30) begin
            q = REQ_AVG + 3'($urandom_range(2));
            send_req(q, p, c, 2'($urandom_range(1)), rand_sample(), rand_sample(),
                     1'b0, '0, ST_VALUE);
            sent++;
          end
        end
        send_req(REQ_AVG, p, c, CH_FIRST, '0, '0, 1'b0, '0, ST_VALUE);
        send_req(REQ_AVG, p, c, CH_SECOND, '0, '0, 1'b0, '0, ST_VALUE);
        sent += 2;
      end else if (pick < 74) begin
        send_req(REQ_CLR_ALL, 1'($urandom_range(1)), 8'($urandom_range(255)),
                 2'($urandom_range(3)), rand_sample(), rand_sample(), 1'b0, '0, ST_VALUE);
        sent++;
      end else if (pick < 78) begin
        send_req(REQ_CLR_CYC, 1'($urandom_range(1)), 8'($urandom_range(255)),
                 2'($urandom_range(3)), rand_sample(), rand_sample(), 1'b0, '0, ST_VALUE);
        sent++;
      end else begin
        send_req(3'($urandom_range(7)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                 2'($urandom_range(3)), rand_sample(), rand_sample(), 1'b0, '0, ST_VALUE);
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic rdy, input int idle_pct, input int stall_pct,
                           input int n_items);
    wait_responses_done();
    write_ready(rdy);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    run_random(n_items);
  endtask

  initial begin
    ready_copy = 1'b0;
    clear_baseline_model(1'b0);
    dir_rows = '{
      // Not ready yet: saves and queries are refused, clears still act.
      '{1'b0, 1'b0, REQ_AVG, 1'b0, 8'd1, CH_FIRST, 32'h0, 32'h0, 1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_SAVE, 1'b0, 8'd1, CH_FIRST, 32'h1234_5678, 32'h9abc_def0,
        1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_CLR_CYC, 1'b1, 8'd255, CH_INVALID_3, 32'h0, 32'h0,
        1'b1, 32'h0, ST_CLEARED},
      '{1'b1, 1'b1, REQ_SAVE, 1'b0, 8'd0, CH_FIRST, 32'h0, 32'h0, 1'b0, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_LAST, 1'b0, 8'd1, CH_FIRST, 32'h0, 32'h0, 1'b1, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_AVG, 1'b1, 8'd4, CH_SECOND, 32'h0, 32'h0, 1'b1, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_SAVE, 1'b0, 8'd1, CH_FIRST, 32'hffff_ffff, 32'h0,
        1'b1, 32'h0, ST_STORED},
      // A save ignores the channel select.
      '{1'b0, 1'b0, REQ_SAVE, 1'b0, 8'd1, CH_INVALID_3, 32'hffff_ffff, 32'h1,
        1'b1, 32'h0, ST_STORED},
      '{1'b0, 1'b0, REQ_AVG, 1'b0, 8'd1, CH_FIRST, 32'h0, 32'h0, 1'b0, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_AVG, 1'b0, 8'd1, CH_SECOND, 32'h0, 32'h0, 1'b0, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_LAST, 1'b0, 8'd1, CH_SECOND, 32'h0, 32'h0, 1'b0, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_CYCLE, 1'b0, 8'd1, CH_FIRST, 32'h0, 32'h0, 1'b0, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_AVG, 1'b0, 8'd1, CH_INVALID_2, 32'h0, 32'h0,
        1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_LAST, 1'b0, 8'd1, CH_INVALID_3, 32'h0, 32'h0,
        1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_SAVE, 1'b0, 8'd0, CH_FIRST, 32'h5, 32'h6, 1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_CYCLE, 1'b1, 8'd5, CH_FIRST, 32'h0, 32'h0, 1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_AVG, 1'b1, 8'd255, CH_SECOND, 32'h0, 32'h0,
        1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_UNDEF_LO, 1'b0, 8'd1, CH_FIRST, 32'h0, 32'h0,
        1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_UNDEF_HI, 1'b1, 8'd4, CH_SECOND, 32'hffff_ffff, 32'hffff_ffff,
        1'b1, 32'h0, ST_REJECT},
      '{1'b0, 1'b0, REQ_SAVE, 1'b1, 8'd4, CH_SECOND, 32'hffff_ffff, 32'hffff_ffff,
        1'b1, 32'h0, ST_STORED},
      '{1'b0, 1'b0, REQ_CLR_CYC, 1'b0, 8'd0, CH_FIRST, 32'h0, 32'h0,
        1'b1, 32'h0, ST_CLEARED},
      '{1'b0, 1'b0, REQ_CYCLE, 1'b0, 8'd1, CH_SECOND, 32'h0, 32'h0, 1'b1, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_LAST, 1'b1, 8'd4, CH_FIRST, 32'h0, 32'h0, 1'b0, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_CLR_ALL, 1'b1, 8'd255, CH_INVALID_2, 32'h0, 32'h0,
        1'b1, 32'h0, ST_CLEARED},
      '{1'b0, 1'b0, REQ_AVG, 1'b1, 8'd4, CH_FIRST, 32'h0, 32'h0, 1'b1, 32'h0, ST_VALUE},
      '{1'b0, 1'b0, REQ_LAST, 1'b0, 8'd1, CH_SECOND, 32'h0, 32'h0, 1'b1, 32'h0, ST_VALUE}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].is_cfg) begin
        wait_responses_done();
        write_ready(dir_rows[i].cfg_val);
      end else begin
        send_req(dir_rows[i].kind, dir_rows[i].port, dir_rows[i].cham, dir_rows[i].ch,
                 dir_rows[i].a, dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].fval,
                 dir_rows[i].fst);
      end
    end

    run_phase(1'b1, 0, 0, 260);
    run_phase(1'b1, 53, 0, 260);
    run_phase(1'b0, 0, 53, 60);
    run_phase(1'b1, 0, 53, 260);
    run_phase(1'b1, 32, 32, 260);
    run_phase(1'b1, 0, 0, 80);

    wait_responses_done();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[%0t] timeout", $time);
    $display("tb: FAIL");
    $finish;
  end

endmodule
